FILE: rtl/page_translation_fifo_replace_core_assert.svh
// Assertion helpers for the page translation core.
`ifndef PAGE_TRANSLATION_FIFO_REPLACE_CORE_ASSERT_SVH
`define PAGE_TRANSLATION_FIFO_REPLACE_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define PTFR_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTFR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ptfr_pkg.sv
package ptfr_pkg;

  localparam int DEF_OFFSET_BITS = 12;
  localparam int DEF_NUM_PAGES   = 16;
  localparam int DEF_NUM_FRAMES  = 8;

  localparam int VA_W     = 16;
  localparam int PHYS_W   = 15;
  localparam int EVP_W    = 4;
  localparam int REF_W    = 16;
  localparam int OUT_DW   = 40;
  localparam int OUT_UW   = 2;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  // output word layout
  localparam int O_PHYS  = 0;
  localparam int O_EVP   = O_PHYS + PHYS_W;
  localparam int O_EVD   = O_EVP + EVP_W;
  localparam int O_REFS  = O_EVD + 1;
  localparam int O_USED  = O_REFS + REF_W;

  localparam int U_HIT   = 0;
  localparam int U_EVICT = 1;

endpackage

FILE: rtl/ptfr_ram.sv
module ptfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/page_translation_fifo_replace_core.sv
// channel | dir | tdata (low bit up)                                   | tuser
// s_*     | in  | virt_addr[15:0]                                      | -
// m_*     | out | phys_addr[14:0] evicted_page[3:0] evicted_dirty      | page_hit
//         |     | frame_refs[15:0], 4 zero pad bits                    | did_evict
// One word at a time. Miss: page table RAM read, then write back.
// Hit: page table read, frame table read, refcount write back.
// Page count not a power of two: an extra ST_MOD step first reduces the page field.
// rst clears valid/dirty bits, fill count and FIFO pointer; RAMs are not cleared.
// A result waiting in the output register stalls only the final write-back step.
module page_translation_fifo_replace_core #(
  parameter int OFFSET_BITS = ptfr_pkg::DEF_OFFSET_BITS,
  parameter int NUM_PAGES   = ptfr_pkg::DEF_NUM_PAGES,
  parameter int NUM_FRAMES  = ptfr_pkg::DEF_NUM_FRAMES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ptfr_pkg::VA_W-1:0]   s_tdata,   // virt_addr
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ptfr_pkg::OUT_DW-1:0] m_tdata,   // phys_addr, evicted_page, evicted_dirty,
                                                 // frame_refs, pad
  output logic [ptfr_pkg::OUT_UW-1:0] m_tuser    // page_hit, did_evict
);

  `include "page_translation_fifo_replace_core_assert.svh"

  localparam int PB  = $clog2(NUM_PAGES);
  localparam int FB  = $clog2(NUM_FRAMES);
  localparam int PIW = (OFFSET_BITS < ptfr_pkg::VA_W) ? ptfr_pkg::VA_W - OFFSET_BITS : 1;
  localparam int RW  = ptfr_pkg::REF_W;
  localparam bit PAGE_POW2 = (NUM_PAGES & (NUM_PAGES - 1)) == 0;
  // reciprocal for page field / NUM_PAGES, exact over the whole page field
  localparam int RS    = PIW + PB;
  localparam int QW    = RS + PIW;
  localparam int RMW   = PIW + PB;
  localparam int RECIP = (2 ** RS + NUM_PAGES - 1) / NUM_PAGES;
  localparam logic [FB:0] FULL_W = (FB + 1)'(NUM_FRAMES);
  localparam logic [FB-1:0] PTR_LAST = FB'(NUM_FRAMES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_HIT  = 2'd3;

  logic [1:0]                state, state_next;
  logic [ptfr_pkg::VA_W-1:0] va_q;
  logic [PIW-1:0]            pfield;
  logic [PIW-1:0]            quot;
  logic [PB-1:0]             page_q;
  logic [FB-1:0]             frame_q;
  logic [NUM_PAGES-1:0]      page_valid, page_valid_next;
  logic [NUM_PAGES-1:0]      page_dirty, page_dirty_next;
  logic [FB:0]               fill;
  logic [FB-1:0]             ptr;

  logic                      accept, out_free, enter, lookup_hit, full;
  logic                      miss_done, hit_done, done;
  logic [ptfr_pkg::VA_W-1:0] page_wide_in;
  logic [PB-1:0]             page_in;
  logic [QW-1:0]             quot_prod;
  logic [RMW-1:0]            qn, rem_wide;
  logic [PB-1:0]             page_mod;
  logic [PB-1:0]             pram_raddr;
  logic [FB-1:0]             pram_rdata;
  logic                      fram_re;
  logic [FB-1:0]             fram_raddr;
  logic [PB+RW-1:0]          fram_rdata, fram_wdata;
  logic [FB-1:0]             new_frame, use_frame;
  logic [PB-1:0]             ev_page;
  logic [RW-1:0]             ref_old, ref_inc, ref_out;
  logic                      ev_dirty;
  logic [31:0]               phys_wide;
  logic [ptfr_pkg::VA_W-1:0] ev_page_wide;

  assign s_tready     = (state == ST_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign page_wide_in = s_tdata >> OFFSET_BITS;
  assign page_in      = page_wide_in[PB-1:0];

  // quotient on accept, remainder in ST_MOD
  assign quot_prod = QW'(page_wide_in[PIW-1:0]) * QW'(RECIP);
  assign qn        = RMW'(quot) * RMW'(NUM_PAGES);
  assign rem_wide  = RMW'(pfield) - qn;
  assign page_mod  = rem_wide[PB-1:0];

  assign enter      = (accept && PAGE_POW2) || (state == ST_MOD);
  assign lookup_hit = page_valid[page_q];
  assign full       = (fill == FULL_W);
  assign pram_raddr = (state == ST_IDLE) ? page_in : page_mod;

  // frame table: victim entry on lookup, mapped frame on a hit
  assign fram_re    = enter || (state == ST_READ && lookup_hit);
  assign fram_raddr = (state == ST_READ) ? pram_rdata : ptr;

  assign miss_done = (state == ST_READ) && !lookup_hit && out_free;
  assign hit_done  = (state == ST_HIT) && out_free;
  assign done      = miss_done || hit_done;

  assign new_frame = full ? ptr : fill[FB-1:0];
  assign use_frame = hit_done ? frame_q : new_frame;
  assign ev_page   = fram_rdata[RW +: PB];
  assign ref_old   = fram_rdata[RW-1:0];
  assign ref_inc   = (ref_old == ptfr_pkg::REF_MAX) ? ref_old : ref_old + RW'(1);
  assign ref_out   = hit_done ? ref_inc : RW'(1);
  assign ev_dirty  = full && page_dirty[ev_page];
  assign fram_wdata = {page_q, ref_out};

  assign phys_wide    = (32'(use_frame) << OFFSET_BITS)
                      | (32'(va_q) & ((32'd1 << OFFSET_BITS) - 32'd1));
  assign ev_page_wide = full ? ptfr_pkg::VA_W'(ev_page) : '0;

  ptfr_ram #(
    .WIDTH (FB),
    .DEPTH (NUM_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (miss_done),
    .waddr (page_q),
    .wdata (new_frame),
    .re    (enter),
    .raddr (pram_raddr),
    .rdata (pram_rdata)
  );

  ptfr_ram #(
    .WIDTH (PB + RW),
    .DEPTH (NUM_FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (done),
    .waddr (use_frame),
    .wdata (fram_wdata),
    .re    (fram_re),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = PAGE_POW2 ? ST_READ : ST_MOD;
        end
      end
      ST_MOD: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        if (lookup_hit) begin
          state_next = ST_HIT;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_HIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    page_valid_next = page_valid;
    page_dirty_next = page_dirty;
    if (miss_done) begin
      if (full) begin
        page_valid_next[ev_page] = 1'b0;
        page_dirty_next[ev_page] = 1'b0;
      end
      page_valid_next[page_q] = 1'b1;
      page_dirty_next[page_q] = 1'b0;
    end
    if (hit_done) begin
      page_dirty_next[page_q] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      page_valid <= '0;
      page_dirty <= '0;
      fill       <= '0;
      ptr        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      page_valid <= page_valid_next;
      page_dirty <= page_dirty_next;
      if (miss_done) begin
        if (full) begin
          ptr <= (ptr == PTR_LAST) ? '0 : ptr + FB'(1);
        end else begin
          fill <= fill + (FB + 1)'(1);
        end
      end
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      va_q   <= s_tdata;
      page_q <= page_in;
      pfield <= page_wide_in[PIW-1:0];
      quot   <= quot_prod[RS +: PIW];
    end
    if (state == ST_MOD) begin
      page_q <= page_mod;
    end
    if (state == ST_READ && lookup_hit) begin
      frame_q <= pram_rdata;
    end
    if (done) begin
      m_tdata <= {{(ptfr_pkg::OUT_DW - ptfr_pkg::O_USED){1'b0}},
                  ref_out,
                  !hit_done && ev_dirty,
                  (hit_done ? {ptfr_pkg::EVP_W{1'b0}} : ev_page_wide[ptfr_pkg::EVP_W-1:0]),
                  phys_wide[ptfr_pkg::PHYS_W-1:0]};
      m_tuser <= {!hit_done && full, hit_done};
    end
  end

  `PTFR_CHECK_NEXT(a_one_word, accept, !s_tready, "second word taken while one is in flight")
  `PTFR_CHECK(a_ptr_until_full, fill != FULL_W, ptr == '0, "FIFO pointer moved before frames full")
  `PTFR_CHECK_NEXT(a_page_mapped, done, page_valid[page_q], "served page left unmapped")

endmodule
